>>> hdl/mrt_pkg.sv
// Package for the microphone RMS level trigger: widths, register indexes,
// reset values, state encoding and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package mrt_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int FL_W            = 9;
  localparam int LVL_W           = 8;
  localparam int RMS_W           = 16;
  localparam int INT_W           = 8;
  localparam int SUM_W           = 32;
  localparam int Q_SH            = 8;
  localparam int DIVD_W          = SUM_W + Q_SH;
  localparam int ROOT_W          = DIVD_W / 2;
  localparam int DIV_STEPS       = DIVD_W;
  localparam int SQRT_STEPS      = DIVD_W / 2;
  localparam int STEP_W          = $clog2(DIV_STEPS);
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = FL_W;

  localparam int MAX_FRAME_DEF   = 256;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_STEPS    = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_LOUD_THRESHOLD = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_COUNT  = CFG_ADDR_W'(3);

  localparam logic [FL_W-1:0]  RST_FRAME_LENGTH   = FL_W'(200);
  localparam logic [LVL_W-1:0] RST_LEVEL_STEPS    = LVL_W'(100);
  localparam logic [LVL_W-1:0] RST_LOUD_THRESHOLD = LVL_W'(6);
  localparam logic [LVL_W-1:0] RST_TRIGGER_COUNT  = LVL_W'(10);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } mrt_state_t;

  typedef struct packed {
    logic [FL_W-1:0]  frame_length;
    logic [LVL_W-1:0] level_steps;
    logic [LVL_W-1:0] loud_threshold;
    logic [LVL_W-1:0] trigger_count;
  } mrt_cfg_t;

  typedef struct packed {
    logic acc;
    logic load;
    logic div_step;
    logic sqrt_step;
    logic finish;
  } mrt_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_free;
  } mrt_sts_t;

endpackage

>>> hdl/mrt_sample_if.sv
// Sample stream channel: valid/ready plus one ADC sample per beat.
// Depends on mrt_pkg.
`timescale 1ns / 1ps
interface mrt_sample_if import mrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> hdl/mrt_result_if.sv
// Result channel: valid/ready plus RMS, intensity and trigger per beat.
// Depends on mrt_pkg.
`timescale 1ns / 1ps
interface mrt_result_if import mrt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_q4;
  logic [INT_W-1:0] intensity;
  logic             trigger;

  modport source (output valid, output rms_q4, output intensity, output trigger, input ready);
  modport sink (input valid, input rms_q4, input intensity, input trigger, output ready);
endinterface

>>> hdl/mrt_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on mrt_pkg.
`timescale 1ns / 1ps
interface mrt_cfg_if import mrt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/mrt_regs.sv
// Configuration register file: decodes write beats into the four settings.
// Depends on mrt_pkg and mrt_cfg_if.
`timescale 1ns / 1ps
module mrt_regs import mrt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mrt_cfg_if.sink    cfg,
  output mrt_cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_length   <= RST_FRAME_LENGTH;
      regs.level_steps    <= RST_LEVEL_STEPS;
      regs.loud_threshold <= RST_LOUD_THRESHOLD;
      regs.trigger_count  <= RST_TRIGGER_COUNT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_LENGTH:   regs.frame_length   <= cfg.data;
        REG_LEVEL_STEPS:    regs.level_steps    <= cfg.data[LVL_W-1:0];
        REG_LOUD_THRESHOLD: regs.loud_threshold <= cfg.data[LVL_W-1:0];
        REG_TRIGGER_COUNT:  regs.trigger_count  <= cfg.data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/mrt_ctrl.sv
// Controller: sequences accumulate, bit-serial divide, digit-serial square
// root and result load. Depends on mrt_pkg.
`timescale 1ns / 1ps
module mrt_ctrl import mrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  mrt_sts_t sts,
  output mrt_cmd_t cmd
);

  localparam logic [STEP_W-1:0] LAST_DIV  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_SQRT = STEP_W'(SQRT_STEPS - 1);

  mrt_state_t        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (sts.frame_end) begin
            cmd.load   = 1'b1;
            cnt_next   = '0;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == LAST_DIV) begin
          cnt_next   = '0;
          state_next = ST_SQRT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == LAST_SQRT) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_ACCUM;
        end
      end
    endcase
  end

  a_div_to_sqrt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == LAST_DIV) |=> (state == ST_SQRT && cnt == '0))
    else $error("divide did not hand over to square root");

  a_sqrt_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT && cnt == LAST_SQRT) |=> (state == ST_DONE))
    else $error("square root did not finish on its last step");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCUM && in_valid && sts.frame_end) |=> (state == ST_DIV && cnt == '0))
    else $error("frame end beat did not start the divide");

endmodule

>>> hdl/mrt_datapath.sv
// Datapath: square accumulator, restoring divider, square root, intensity,
// loud-frame counter and output register. Depends on mrt_pkg, mrt_result_if.
`timescale 1ns / 1ps
module mrt_datapath import mrt_pkg::*; #(
  parameter int MAX_FRAME   = MAX_FRAME_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] sample,
  input  mrt_cfg_t            regs,
  input  mrt_cmd_t            cmd,
  output mrt_sts_t            sts,
  mrt_result_if.source        results
);

  localparam int NW     = $clog2(MAX_FRAME + 1);
  localparam int DR_W   = NW + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int MID_SH = SAMPLE_BITS + 3;
  localparam int PROD_W = LVL_W + RMS_W;
  localparam int SQR_W  = ROOT_W + 3;
  localparam logic [RMS_W-1:0]  MID     = RMS_W'(1) << MID_SH;
  localparam logic [PROD_W-1:0] INT_SAT = PROD_W'((1 << INT_W) - 1);
  localparam logic [LVL_W-1:0]  LOUD_MAX = '1;

  logic [NW-1:0]          n_eff;
  logic [SAMPLE_BITS-1:0] s;
  logic [SQ_W-1:0]        sq;
  logic [SUM_W-1:0]       sum, sum_next;
  logic [FL_W-1:0]        idx, idx_inc;

  logic [DIVD_W-1:0]      work;
  logic [DR_W-1:0]        div_rem, div_sh;
  logic                   div_ge;
  logic [SQR_W-1:0]       sq_rem, sq_sh, trial;
  logic                   sq_ge;
  logic [ROOT_W-1:0]      root;

  logic [RMS_W-1:0]       rms, dev;
  logic [PROD_W-1:0]      prod, int_q;
  logic [INT_W-1:0]       intensity;
  logic [LVL_W-1:0]       loud, loud_inc;
  logic                   trig;

  logic                   out_valid;
  logic [RMS_W-1:0]       out_rms;
  logic [INT_W-1:0]       out_int;
  logic                   out_trig;

  always_comb begin
    priority if (regs.frame_length == '0) begin
      n_eff = NW'(1);
    end else if (regs.frame_length > FL_W'(MAX_FRAME)) begin
      n_eff = NW'(MAX_FRAME);
    end else begin
      n_eff = regs.frame_length[NW-1:0];
    end
  end

  assign s             = sample[SAMPLE_BITS-1:0];
  assign sq            = SQ_W'(s) * SQ_W'(s);
  assign sum_next      = sum + SUM_W'(sq);
  assign idx_inc       = idx + 1'b1;
  assign sts.frame_end = idx_inc >= FL_W'(n_eff);
  assign sts.out_free  = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      idx <= '0;
    end else if (cmd.acc) begin
      if (sts.frame_end) begin
        sum <= '0;
        idx <= '0;
      end else begin
        sum <= sum_next;
        idx <= idx_inc;
      end
    end
  end

  // restoring divide, one quotient bit per step
  assign div_sh = {div_rem[DR_W-2:0], work[DIVD_W-1]};
  assign div_ge = div_sh >= DR_W'(n_eff);

  // digit-by-digit square root on the quotient, two radicand bits per step
  assign sq_sh  = {sq_rem[SQR_W-3:0], work[DIVD_W-1 -: 2]};
  assign trial  = SQR_W'({root, 2'b01});
  assign sq_ge  = sq_sh >= trial;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work    <= {sum_next, {Q_SH{1'b0}}};
      div_rem <= '0;
      sq_rem  <= '0;
      root    <= '0;
    end else if (cmd.div_step) begin
      work    <= {work[DIVD_W-2:0], div_ge};
      div_rem <= div_ge ? (div_sh - DR_W'(n_eff)) : div_sh;
    end else if (cmd.sqrt_step) begin
      work    <= {work[DIVD_W-3:0], 2'b00};
      sq_rem  <= sq_ge ? (sq_sh - trial) : sq_sh;
      root    <= {root[ROOT_W-2:0], sq_ge};
    end
  end

  assign rms   = root[RMS_W-1:0];
  assign dev   = (rms >= MID) ? (rms - MID) : (MID - rms);
  assign prod  = PROD_W'(regs.level_steps) * PROD_W'(dev);
  assign int_q = (prod - 1'b1) >> MID_SH;

  always_comb begin
    priority if (prod == '0) begin
      intensity = '0;
    end else if (int_q > INT_SAT) begin
      intensity = '1;
    end else begin
      intensity = int_q[INT_W-1:0];
    end
  end

  assign loud_inc = (intensity >= regs.loud_threshold && loud != LOUD_MAX) ?
                    (loud + 1'b1) : loud;
  assign trig     = loud_inc >= regs.trigger_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      loud      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        loud      <= trig ? '0 : loud_inc;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_rms  <= rms;
      out_int  <= intensity;
      out_trig <= trig;
    end
  end

  assign results.valid     = out_valid;
  assign results.rms_q4    = out_rms;
  assign results.intensity = out_int;
  assign results.trigger   = out_trig;

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || results.ready))
    else $error("result loaded over an untaken beat");

  a_trig_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && trig) |=> (loud == '0 && results.trigger))
    else $error("trigger did not clear the loud-frame count");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (sum == '0 && idx == '0))
    else $error("frame end did not clear the accumulator");

endmodule

>>> hdl/mic_rms_level_trigger_core.sv
// Microphone RMS level trigger, top level: config registers, controller
// and datapath. Depends on mrt_pkg, the three channel interfaces and
// mrt_regs, mrt_ctrl, mrt_datapath.
//
// Usage:
//   samples : one ADC code per beat, low SAMPLE_BITS bits used.
//   cfg     : register writes (0 frame_length, 1 level_steps,
//             2 loud_threshold, 3 trigger_count); ready is always high.
//   results : one beat per frame with rms_q4, intensity and trigger.
// Samples are taken one per cycle while the controller accumulates. The
// beat that ends a frame starts a 40-step bit-serial divide by the frame
// length and a 20-step square root; the result register loads once both
// are done and the register is free, and samples are held off until then.
// A result waits in the output register while the receiver stalls; the next
// frame accumulates meanwhile, and once its divide and root are done samples
// stay held off until the register is free. Reset clears the accumulator,
// loud-frame count and output valid and loads the register defaults 200,
// 100, 6 and 10.
`timescale 1ns / 1ps
module mic_rms_level_trigger_core import mrt_pkg::*; #(
  parameter int MAX_FRAME   = MAX_FRAME_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mrt_sample_if.sink    samples,
  mrt_result_if.source  results,
  mrt_cfg_if.sink       cfg
);

  mrt_cfg_t regs;
  mrt_cmd_t cmd;
  mrt_sts_t sts;
  logic     in_ready;

  assign samples.ready = in_ready;

  mrt_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrt_datapath #(
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .sample  (samples.sample),
    .regs    (regs),
    .cmd     (cmd),
    .sts     (sts),
    .results (results)
  );

endmodule

>>> dv/mrt_level_checker.sv
// Checker for the microphone RMS level trigger: follows the sample, result
// and configuration channels, predicts each frame result and compares it.
// Depends on mrt_pkg and the three channel interfaces.
`timescale 1ns / 1ps
module mrt_level_checker import mrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  mrt_sample_if samples,
  mrt_result_if results,
  mrt_cfg_if    cfg,
  output int    errors,
  output int    pending
);

  localparam int MID_Q4      = 1 << (SAMPLE_BITS_DEF + 3);
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [RMS_W-1:0] rms_q4;
    logic [INT_W-1:0] intensity;
    logic             trigger;
  } frame_level_t;

  frame_level_t     level_q[$];
  mrt_cfg_t         regs;
  logic [SUM_W-1:0] square_sum;
  logic [FL_W-1:0]  frame_fill;
  logic [LVL_W-1:0] loud_frames;

  function automatic logic [RMS_W-1:0] floor_sqrt(input logic [DIVD_W-1:0] v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return RMS_W'(root);
  endfunction

  task automatic take_sample(input logic [SAMPLE_W-1:0] code);
    logic [SAMPLE_BITS_DEF-1:0] s;
    logic [DIVD_W-1:0]          mean_sq;
    logic [RMS_W-1:0]           rms;
    int unsigned                frame_n;
    int unsigned                dev_q4;
    int unsigned                weighted;
    int unsigned                steps;
    frame_level_t               lvl;
    s = code[SAMPLE_BITS_DEF-1:0];
    if (regs.frame_length == 0) frame_n = 1;
    else if (regs.frame_length > MAX_FRAME_DEF) frame_n = MAX_FRAME_DEF;
    else frame_n = regs.frame_length;
    square_sum = square_sum + SUM_W'(s) * SUM_W'(s);
    frame_fill = frame_fill + 1'b1;
    if (frame_fill >= frame_n) begin
      mean_sq  = {square_sum, {Q_SH{1'b0}}} / DIVD_W'(frame_n);
      rms      = floor_sqrt(mean_sq);
      dev_q4   = (rms >= MID_Q4) ? rms - MID_Q4 : MID_Q4 - rms;
      weighted = regs.level_steps * dev_q4;
      steps    = (weighted == 0) ? 0 : (weighted - 1) / MID_Q4;
      if (steps > 255) steps = 255;
      lvl.rms_q4    = rms;
      lvl.intensity = INT_W'(steps);
      lvl.trigger   = 1'b0;
      if (steps >= regs.loud_threshold && loud_frames != '1)
        loud_frames = loud_frames + 1'b1;
      if (loud_frames >= regs.trigger_count) begin
        lvl.trigger = 1'b1;
        loud_frames = '0;
      end
      square_sum = '0;
      frame_fill = '0;
      level_q.push_back(lvl);
    end
  endtask

  task automatic check_level(input frame_level_t got);
    frame_level_t want;
    if (level_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected result beat: rms_q4=%0d intensity=%0d trigger=%0b",
                 got.rms_q4, got.intensity, got.trigger);
    end else begin
      want = level_q.pop_front();
      if (got.rms_q4 !== want.rms_q4 || got.intensity !== want.intensity ||
          got.trigger !== want.trigger) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result mismatch (rms_q4/intensity/trigger): want %0d/%0d/%0b, got %0d/%0d/%0b",
                   want.rms_q4, want.intensity, want.trigger,
                   got.rms_q4, got.intensity, got.trigger);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.frame_length   = RST_FRAME_LENGTH;
      regs.level_steps    = RST_LEVEL_STEPS;
      regs.loud_threshold = RST_LOUD_THRESHOLD;
      regs.trigger_count  = RST_TRIGGER_COUNT;
      square_sum  = '0;
      frame_fill  = '0;
      loud_frames = '0;
      errors      = 0;
      level_q.delete();
    end else begin
      if (results.valid && results.ready)
        check_level({results.rms_q4, results.intensity, results.trigger});
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FRAME_LENGTH:   regs.frame_length   = cfg.data;
          REG_LEVEL_STEPS:    regs.level_steps    = cfg.data[LVL_W-1:0];
          REG_LOUD_THRESHOLD: regs.loud_threshold = cfg.data[LVL_W-1:0];
          REG_TRIGGER_COUNT:  regs.trigger_count  = cfg.data[LVL_W-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) take_sample(samples.sample);
    end
    pending = level_q.size();
  end

endmodule

>>> dv/tb.sv
// Testbench top for mic_rms_level_trigger_core: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on mrt_pkg, the channel interfaces and mrt_level_checker.
`timescale 1ns / 1ps
module tb import mrt_pkg::*; ();

  localparam int SAMPLE_TARGET = 800;
  localparam int CALM_TAIL     = 150;
  localparam int SETTLE_CYCLES = 80;
  localparam int MID_CODE      = 1 << (SAMPLE_W - 1);
  localparam int FULL_CODE     = (1 << SAMPLE_W) - 1;
  localparam int SPARE_FIRST   = 4;
  localparam int SPARE_LAST    = (1 << CFG_ADDR_W) - 1;

  typedef enum int {TONE_NOISE, TONE_QUIET, TONE_LOUD, TONE_SWING} tone_t;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;
  int   sent      = 0;
  int   gap_pct   = 25;
  int   stall_pct = 25;
  bit   calm      = 1'b0;

  mrt_sample_if samples_if ();
  mrt_result_if results_if ();
  mrt_cfg_if    cfg_if ();

  mic_rms_level_trigger_core dut (
    .clk(clk), .rst(rst), .samples(samples_if), .results(results_if), .cfg(cfg_if)
  );

  mrt_level_checker level_chk (
    .clk(clk), .rst(rst), .samples(samples_if), .results(results_if), .cfg(cfg_if),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] pick_sample(input tone_t tone, input int amp);
    case (tone)
      TONE_QUIET: return SAMPLE_W'(MID_CODE - 32 + $urandom_range(0, 64));
      TONE_LOUD: begin
        if ($urandom_range(0, 1)) return SAMPLE_W'($urandom_range(0, 63));
        return SAMPLE_W'(FULL_CODE - $urandom_range(0, 63));
      end
      TONE_SWING: return SAMPLE_W'(MID_CODE - amp + $urandom_range(0, 2 * amp));
      default: return SAMPLE_W'($urandom_range(0, FULL_CODE));
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] code);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= code;
    do @(posedge clk); while (!samples_if.ready);
    sent++;
    if (sent >= SAMPLE_TARGET - CALM_TAIL) calm = 1'b1;
  endtask

  // drop valid, then wait out every expected frame and the tail latency
  task automatic settle();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_ADDR_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic load_settings(input logic [FL_W-1:0] fl, input logic [LVL_W-1:0] ls,
                               input logic [LVL_W-1:0] th, input logic [LVL_W-1:0] tc);
    settle();
    if ($urandom_range(0, 3) == 0)
      cfg_beat(CFG_ADDR_W'($urandom_range(SPARE_FIRST, SPARE_LAST)), CFG_DATA_W'($urandom));
    cfg_beat(REG_FRAME_LENGTH, fl);
    // upper data bit is outside the 8-bit registers
    cfg_beat(REG_LEVEL_STEPS, {1'($urandom_range(0, 1)), ls});
    cfg_beat(REG_LOUD_THRESHOLD, {1'($urandom_range(0, 1)), th});
    cfg_beat(REG_TRIGGER_COUNT, {1'($urandom_range(0, 1)), tc});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [FL_W-1:0] fl, input logic [LVL_W-1:0] ls,
                           input logic [LVL_W-1:0] th, input logic [LVL_W-1:0] tc);
    int    eff;
    int    frames;
    int    amp;
    tone_t tone;
    gap_pct   = 25 * $urandom_range(0, 2);
    stall_pct = 25 * $urandom_range(0, 2);
    load_settings(fl, ls, th, tc);
    eff = (fl == 0) ? 1 : (fl > MAX_FRAME_DEF) ? MAX_FRAME_DEF : fl;
    frames = (eff > 64) ? 1 : $urandom_range(3, 10);
    for (int f = 0; f < frames; f++) begin
      tone = tone_t'($urandom_range(0, 3));
      amp  = $urandom_range(1, MID_CODE - 1);
      for (int i = 0; i < eff; i++) send_sample(pick_sample(tone, amp));
    end
    // partial frame carried into the next settings
    if (eff > 1 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, eff - 1)) send_sample(pick_sample(TONE_NOISE, 0));
  endtask

  initial begin
    results_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        results_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic [FL_W-1:0] fl;
    int              pick;
    rst               = 1'b1;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // one-sample frames at the code extremes and mid-scale, every frame loud and firing
    load_settings(FL_W'(1), 8'd255, 8'd0, 8'd1);
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(FULL_CODE));
    send_sample(SAMPLE_W'(MID_CODE));
    send_sample(SAMPLE_W'(MID_CODE - 1));
    // zero length acts as one, zero steps, zero trigger count
    load_settings(FL_W'(0), 8'd0, 8'd255, 8'd0);
    send_sample(SAMPLE_W'(FULL_CODE));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'($urandom));
    // three loud frames fire the trigger, then quieter ones
    load_settings(FL_W'(2), 8'd200, 8'd100, 8'd3);
    repeat (2) send_sample(SAMPLE_W'(FULL_CODE));
    repeat (2) send_sample(SAMPLE_W'(0));
    repeat (2) send_sample(SAMPLE_W'(FULL_CODE));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(FULL_CODE));
    repeat (2) send_sample(SAMPLE_W'(MID_CODE));
    // frame length lowered below the current fill
    load_settings(FL_W'(8), 8'd100, 8'd6, 8'd2);
    repeat (5) send_sample(SAMPLE_W'($urandom));
    load_settings(FL_W'(3), 8'd100, 8'd6, 8'd2);
    repeat (4) send_sample(SAMPLE_W'($urandom));

    sent = 0;
    for (int p = 0; sent < SAMPLE_TARGET; p++) begin
      if (p == 0) begin
        run_phase('1, 8'd255, 8'd255, 8'd255);
      end else if (p == 1) begin
        run_phase(FL_W'(MAX_FRAME_DEF), 8'd1, 8'd0, 8'd1);
      end else begin
        pick = $urandom_range(0, 15);
        if (pick == 0) fl = '0;
        else if (pick == 1) fl = FL_W'($urandom_range(65, 511));
        else if (pick < 4) fl = FL_W'($urandom_range(17, 64));
        else fl = FL_W'($urandom_range(1, 16));
        run_phase(fl, LVL_W'($urandom_range(0, 255)),
                  $urandom_range(0, 1) ? LVL_W'($urandom_range(0, 255))
                                       : LVL_W'($urandom_range(0, 30)),
                  ($urandom_range(0, 7) == 0) ? LVL_W'($urandom_range(0, 255))
                                              : LVL_W'($urandom_range(0, 4)));
      end
    end

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
